// ===== rtl/core/encoder_multiturn_speed_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Encoder tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ENCODER_MULTITURN_SPEED_TRACKER_CORE_DEFINES_SVH
`define ENCODER_MULTITURN_SPEED_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define EMST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EMST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/emst_pkg.sv =====
// ----------------------------------------------------------------------------
// emst_pkg
// Widths, constants and the queued work word of the encoder tracker.
// ----------------------------------------------------------------------------
package emst_pkg;

	localparam int ANGLE_W         = 14;
	localparam int TIME_W          = 32;
	localparam int TOTAL_W         = 32;
	localparam int TURNS_W         = 18;
	localparam int SPEED_W         = 20;
	localparam int DIFF_W          = 15;
	localparam int MAG_W           = 14;
	localparam int SCALE_W         = 11;
	localparam int PROD_W          = MAG_W + SCALE_W;
	localparam int QSHIFT          = 5;
	// The scaled count change that enters the speed divider.
	localparam int DVD_W           = PROD_W - QSHIFT;
	localparam int TURN_SHIFT      = 14;
	localparam int HALF_TURN       = 8192;
	localparam int COUNTS_PER_TURN = 16384;
	localparam int SPEED_MAX       = 480000;

	localparam logic [SCALE_W-1:0] SPEED_SCALE = 11'd1875;

	typedef struct packed {
		logic        [ANGLE_W-1:0] angle;
		logic signed [TOTAL_W-1:0] total;
		logic signed [TURNS_W-1:0] turns;
		logic signed [DIFF_W-1:0]  diff;
		logic        [TIME_W-1:0]  elapsed;
		logic                      upd;
	} work_t;

endpackage

// ===== rtl/core/encoder_multiturn_speed_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Encoder multi-turn and speed tracker core
// Each word carries the two raw angle register bytes of an absolute encoder and
// a millisecond timestamp. The core forms the 14-bit angle, wraps the change
// from the previous angle into one half turn either way, and keeps a saturating
// 32-bit count total together with whole turns (truncated toward zero). When
// the timestamp has moved, it makes a speed sample in 1/16 rpm, stores it in a
// FILTER_DEPTH-entry ring (zero after reset) and reports the truncated ring
// mean. Exactly one result word leaves for every input word, in order. A sample
// with elapsed time holds the back end mostly in the speed divider, which makes
// one quotient bit per cycle over the 20-bit scaled count change; the ring mean
// comes from a reciprocal multiply in load, multiply and sign steps at any
// depth. A sample with no elapsed time skips the divider and the ring. The front
// end and a two-entry queue keep taking samples while the back end divides and
// while a finished result waits on out_ready.
// ----------------------------------------------------------------------------
`include "encoder_multiturn_speed_tracker_core_defines.svh"

module encoder_multiturn_speed_tracker_core import emst_pkg::*; #(
	parameter int FILTER_DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                angle_high,
	input  logic [7:0]                angle_low,
	input  logic [TIME_W-1:0]         time_ms,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ANGLE_W-1:0]        angle_count,
	output logic signed [TOTAL_W-1:0] turn_total_out,
	output logic signed [TURNS_W-1:0] full_turns,
	output logic signed [SPEED_W-1:0] rpm_now_x16,
	output logic signed [SPEED_W-1:0] rpm_mean_x16,
	output logic                      speed_updated
);

	logic              push_valid;
	logic              push_ready;
	work_t             push_word;
	logic              pop_valid;
	logic              pop_ready;
	work_t             pop_word;
	logic              div_start;
	logic [DVD_W-1:0]  div_dividend;
	logic [TIME_W-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [DVD_W-1:0]  div_quotient;

	logic                      now_in_range;
	logic                      mean_in_range;
	logic signed [TURNS_W-1:0] turns_check;

	// Front end: angle unwrapping, elapsed time and the saturating total.
	emst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.angle_high (angle_high),
		.angle_low  (angle_low),
		.time_ms    (time_ms),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	// The queue lets the front end run ahead while the back end is dividing.
	emst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	// The divider turns the scaled count change into a speed sample.
	emst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Back end: speed, filter ring, mean and the output register.
	emst_back #(
		.FILTER_DEPTH (FILTER_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_word       (pop_word),
		.div_start      (div_start),
		.div_dividend   (div_dividend),
		.div_divisor    (div_divisor),
		.div_done       (div_done),
		.div_quotient   (div_quotient),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.angle_count    (angle_count),
		.turn_total_out (turn_total_out),
		.full_turns     (full_turns),
		.rpm_now_x16    (rpm_now_x16),
		.rpm_mean_x16   (rpm_mean_x16),
		.speed_updated  (speed_updated)
	);

	assign now_in_range  = (rpm_now_x16 <= SPEED_MAX) && (rpm_now_x16 >= -SPEED_MAX);
	assign mean_in_range = (rpm_mean_x16 <= SPEED_MAX) && (rpm_mean_x16 >= -SPEED_MAX);
	assign turns_check   = turn_total_out[TOTAL_W-1:TURN_SHIFT]
		+ TURNS_W'(turn_total_out[TOTAL_W-1] && (|turn_total_out[TURN_SHIFT-1:0]));

	// A new division must never start on top of one still running.
	`EMST_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")

	// A started division keeps the divider busy in the following cycle.
	`EMST_ASSERT_NEXT(a_div_runs, div_start, div_busy, "divider did not run after start")

	// Both speed outputs stay within the physical range of the scaled quotient.
	`EMST_ASSERT_NOW(a_speed_range, out_valid, now_in_range && mean_in_range, "speed out of range")

	// Whole turns delivered must agree with the total delivered beside them.
	`EMST_ASSERT_NOW(a_turns_match, out_valid, full_turns == turns_check, "turn count disagrees")

endmodule

// ===== rtl/core/emst_front.sv =====
// ----------------------------------------------------------------------------
// emst_front
// Takes input words, tracks angle, time and the saturating total, and builds
// one work word per sample for the speed back end.
// ----------------------------------------------------------------------------
module emst_front import emst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          angle_high,
	input  logic [7:0]          angle_low,
	input  logic [TIME_W-1:0]   time_ms,
	output logic                push_valid,
	input  logic                push_ready,
	output work_t               push_word
);

	logic [ANGLE_W-1:0]        last_angle_q;
	logic [TIME_W-1:0]         last_time_q;
	logic signed [TOTAL_W-1:0] total_q;

	logic                      valid_s1;
	logic [ANGLE_W-1:0]        angle_s1;
	logic signed [DIFF_W-1:0]  diff_s1;
	logic [TIME_W-1:0]         elapsed_s1;
	logic signed [TOTAL_W-1:0] total_s1;

	logic                      accept;
	logic [ANGLE_W-1:0]        angle;
	logic signed [ANGLE_W+1:0] raw_diff;
	logic signed [ANGLE_W+1:0] wrap_diff;
	logic signed [DIFF_W-1:0]  diff;
	logic [TOTAL_W:0]          sum_ext;
	logic signed [TOTAL_W-1:0] total_nx;

	assign in_ready = !valid_s1 || push_ready;
	assign accept   = in_valid && in_ready;
	assign angle    = {angle_high, angle_low[7:2]};

	always_comb begin
		raw_diff = $signed({2'b00, angle}) - $signed({2'b00, last_angle_q});
		if (raw_diff > HALF_TURN) begin
			wrap_diff = raw_diff - (ANGLE_W+2)'(COUNTS_PER_TURN);
		end else if (raw_diff < -HALF_TURN) begin
			wrap_diff = raw_diff + (ANGLE_W+2)'(COUNTS_PER_TURN);
		end else begin
			wrap_diff = raw_diff;
		end
		diff = DIFF_W'(wrap_diff);

		sum_ext = {total_q[TOTAL_W-1], total_q}
			+ {{(TOTAL_W+1-DIFF_W){diff[DIFF_W-1]}}, diff};
		if (sum_ext[TOTAL_W] != sum_ext[TOTAL_W-1]) begin
			total_nx = sum_ext[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
				: {1'b0, {(TOTAL_W-1){1'b1}}};
		end else begin
			total_nx = sum_ext[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			last_time_q  <= '0;
			total_q      <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				last_angle_q <= angle;
				last_time_q  <= time_ms;
				total_q      <= total_nx;
				valid_s1     <= 1'b1;
			end else if (push_valid && push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_s1   <= angle;
			diff_s1    <= diff;
			elapsed_s1 <= time_ms - last_time_q;
			total_s1   <= total_nx;
		end
	end

	// Turns truncate toward zero, so a negative total with a partial turn rounds up.
	assign push_valid         = valid_s1;
	assign push_word.angle    = angle_s1;
	assign push_word.total    = total_s1;
	assign push_word.turns    = total_s1[TOTAL_W-1:TURN_SHIFT]
		+ TURNS_W'(total_s1[TOTAL_W-1] && (|total_s1[TURN_SHIFT-1:0]));
	assign push_word.diff     = diff_s1;
	assign push_word.elapsed  = elapsed_s1;
	assign push_word.upd      = (elapsed_s1 != '0);

endmodule

// ===== rtl/core/emst_queue.sv =====
// ----------------------------------------------------------------------------
// emst_queue
// Two-entry queue of work words between the front end and the back end.
// ----------------------------------------------------------------------------
module emst_queue import emst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_word,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_word
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);

	work_t            slot_mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (PTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = slot_mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_mem[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/core/emst_div.sv =====
// ----------------------------------------------------------------------------
// emst_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emst_div import emst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DVD_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W-1:0] rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [TIME_W:0]   rem_shift;
	logic [TIME_W:0]   rem_sub;
	logic              q_bit;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign rem_sub   = rem_shift - {1'b0, divisor};
	assign q_bit     = !rem_sub[TIME_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= q_bit ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== rtl/core/emst_back.sv =====
// ----------------------------------------------------------------------------
// emst_back
// Works off queued samples: speed division, filter ring update, ring mean by
// reciprocal multiply and the output register.
// ----------------------------------------------------------------------------
module emst_back import emst_pkg::*; #(
	parameter int FILTER_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  work_t                      pop_word,
	output logic                       div_start,
	output logic [DVD_W-1:0]           div_dividend,
	output logic [TIME_W-1:0]          div_divisor,
	input  logic                       div_done,
	input  logic [DVD_W-1:0]           div_quotient,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ANGLE_W-1:0]         angle_count,
	output logic signed [TOTAL_W-1:0]  turn_total_out,
	output logic signed [TURNS_W-1:0]  full_turns,
	output logic signed [SPEED_W-1:0]  rpm_now_x16,
	output logic signed [SPEED_W-1:0]  rpm_mean_x16,
	output logic                       speed_updated
);

	localparam int SUM_W  = SPEED_W + $clog2(FILTER_DEPTH);
	localparam int SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

	// The sum magnitude fits in MAG_N bits. Multiplying by the rounded-up
	// reciprocal and shifting by MAG_N plus the log of the depth gives the
	// exact truncated quotient for every magnitude of that width.
	localparam int     MAG_N   = SUM_W - 1;
	localparam int     RSHIFT  = MAG_N + $clog2(FILTER_DEPTH);
	localparam int     RECIP_W = MAG_N + 2;
	localparam int     MPROD_W = MAG_N + RECIP_W;
	localparam longint RECIP_L = ((longint'(1) << RSHIFT) / longint'(FILTER_DEPTH)) + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVS,
		ST_RING,
		ST_MLOAD,
		ST_DIVM,
		ST_MSIGN,
		ST_DONE
	} state_t;

	state_t                    state_q;
	work_t                     wk_q;
	logic                      start_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [TIME_W-1:0]         dvs_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [SPEED_W-1:0] last_speed_q;
	logic signed [SPEED_W-1:0] mean_q;
	logic [MAG_N-1:0]          mag_q;
	logic signed [SPEED_W-1:0] mquo_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [FILTER_DEPTH-1:0]   vld_q;
	logic signed [SPEED_W-1:0] rd_q;
	logic signed [SPEED_W-1:0] ring_mem [FILTER_DEPTH];

	logic                      out_valid_q;
	logic                      ring_we;
	logic signed [DIFF_W-1:0]  diff_abs;
	logic [PROD_W-1:0]         prod;
	logic signed [SPEED_W-1:0] old_speed;
	logic signed [SUM_W-1:0]   sum_abs;
	logic [MPROD_W-1:0]        mprod;
	logic signed [SPEED_W-1:0] quo_s;

	assign pop_ready    = (state_q == ST_IDLE);
	assign div_start    = start_q;
	assign div_dividend = dvd_q;
	assign div_divisor  = dvs_q;
	assign out_valid    = out_valid_q;
	assign ring_we      = (state_q == ST_RING);

	assign diff_abs  = wk_q.diff[DIFF_W-1] ? -wk_q.diff : wk_q.diff;
	assign prod      = PROD_W'(diff_abs[MAG_W-1:0]) * PROD_W'(SPEED_SCALE);
	assign old_speed = vld_q[slot_q] ? rd_q : '0;
	assign sum_abs   = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mprod     = MPROD_W'(mag_q) * MPROD_W'(RECIP);
	assign quo_s     = SPEED_W'(div_quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wk_q           <= '0;
			start_q        <= 1'b0;
			dvd_q          <= '0;
			dvs_q          <= '0;
			speed_q        <= '0;
			last_speed_q   <= '0;
			mean_q         <= '0;
			mag_q          <= '0;
			mquo_q         <= '0;
			sum_q          <= '0;
			slot_q         <= '0;
			vld_q          <= '0;
			out_valid_q    <= 1'b0;
			angle_count    <= '0;
			turn_total_out <= '0;
			full_turns     <= '0;
			rpm_now_x16    <= '0;
			rpm_mean_x16   <= '0;
			speed_updated  <= 1'b0;
		end else begin
			start_q <= (state_q == ST_MUL);
			// In the result state the register is either refilled or still waiting.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						wk_q    <= pop_word;
						state_q <= pop_word.upd ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					dvd_q   <= DVD_W'(prod >> QSHIFT);
					dvs_q   <= wk_q.elapsed;
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					if (div_done) begin
						speed_q <= wk_q.diff[DIFF_W-1] ? -quo_s : quo_s;
						state_q <= ST_RING;
					end
				end
				ST_RING: begin
					sum_q          <= sum_q - SUM_W'(old_speed) + SUM_W'(speed_q);
					vld_q[slot_q]  <= 1'b1;
					last_speed_q   <= speed_q;
					slot_q         <= (slot_q == SLOT_W'(FILTER_DEPTH - 1)) ? '0
						: slot_q + 1'b1;
					state_q        <= ST_MLOAD;
				end
				ST_MLOAD: begin
					mag_q   <= MAG_N'(sum_abs);
					state_q <= ST_DIVM;
				end
				ST_DIVM: begin
					mquo_q  <= SPEED_W'(mprod >> RSHIFT);
					state_q <= ST_MSIGN;
				end
				ST_MSIGN: begin
					mean_q  <= sum_q[SUM_W-1] ? -mquo_q : mquo_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						angle_count    <= wk_q.angle;
						turn_total_out <= wk_q.total;
						full_turns     <= wk_q.turns;
						rpm_now_x16    <= last_speed_q;
						rpm_mean_x16   <= mean_q;
						speed_updated  <= wk_q.upd;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The read port follows the current slot; it has long settled before the ring step.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= speed_q;
		end
		rd_q <= ring_mem[slot_q];
	end

endmodule
